[rtl/sdr_pkg.sv]
// ----------------------------------------------------------------------------
// sdr_pkg: shared types and constants for the duplicate remover
// Command and status groups between controller and datapath, field widths.
// ----------------------------------------------------------------------------
package sdr_pkg;

  // Default number of distinct values held per array
  localparam int unsigned TableDepthDef = 128;

  // Fixed field widths
  localparam int unsigned ValueW = 32;
  localparam int unsigned KeptW  = 8;

  // Controller to datapath
  typedef struct packed {
    logic start;   // latch a new item, rewind the scan
    logic scan;    // walk the table one entry a cycle
    logic decide;  // capture the keep decision
    logic keep;    // decision value: first occurrence
    logic emit;    // record and load the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;        // compared entry equals the item value
    logic exhausted;  // every recorded entry has been read
    logic out_free;   // output register can take a result
  } status_t;

endpackage

[rtl/sdr_ctrl.sv]
// ----------------------------------------------------------------------------
// sdr_ctrl: sequencing state machine
// Accepts an item, steers the table walk, then hands the result out.
// ----------------------------------------------------------------------------
module sdr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sdr_pkg::status_t status_i,
  output sdr_pkg::cmd_t    cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = StScan;
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (status_i.hit) begin
          cmd_o.decide = 1'b1;
          cmd_o.keep   = 1'b0;
          state_d      = StEmit;
        end else if (status_i.exhausted) begin
          cmd_o.decide = 1'b1;
          cmd_o.keep   = 1'b1;
          state_d      = StEmit;
        end
      end
      StEmit: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/sdr_dpath.sv]
// ----------------------------------------------------------------------------
// sdr_dpath: table memory, comparator, count and output register
// Walks recorded values through one read port and records first occurrences.
// ----------------------------------------------------------------------------
module sdr_dpath #(
  parameter int unsigned TableDepth = sdr_pkg::TableDepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sdr_pkg::cmd_t              cmd_i,
  output sdr_pkg::status_t           status_o,
  input  logic [sdr_pkg::ValueW-1:0] value_i,
  input  logic                       last_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [sdr_pkg::ValueW-1:0] value_o,
  output logic                       keep_o,
  output logic                       last_o,
  output logic                       overflow_o,
  output logic [sdr_pkg::KeptW-1:0]  kept_count_o
);

  localparam int unsigned AddrW = $clog2(TableDepth);
  localparam int unsigned CntW  = $clog2(TableDepth + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(TableDepth);

  logic [sdr_pkg::ValueW-1:0] mem_q [TableDepth];
  logic [sdr_pkg::ValueW-1:0] rdata_q;
  logic [sdr_pkg::ValueW-1:0] item_q;
  logic                       item_last_q;
  logic                       keep_q;
  logic [CntW-1:0]            idx_q, idx_d;
  logic [CntW-1:0]            count_q, count_d;
  logic                       cmp_vld_q, cmp_vld_d;
  logic                       rd_en;
  logic                       room;
  logic                       record;
  logic [CntW-1:0]            count_new;
  logic                       out_valid_q;
  logic [sdr_pkg::ValueW-1:0] out_value_q;
  logic                       out_keep_q;
  logic                       out_last_q;
  logic                       out_ovf_q;
  logic [sdr_pkg::KeptW-1:0]  out_kept_q;

  // Scan pointer and compare qualifier
  assign rd_en = cmd_i.scan && (idx_q < count_q);

  always_comb begin
    idx_d     = idx_q;
    cmp_vld_d = cmp_vld_q;
    if (cmd_i.start) begin
      idx_d     = '0;
      cmp_vld_d = 1'b0;
    end else if (cmd_i.scan) begin
      cmp_vld_d = rd_en;
      if (rd_en) begin
        idx_d = idx_q + CntW'(1);
      end
    end
  end

  // Record decision and next count
  assign room      = (count_q != CntFull);
  assign record    = keep_q && room;
  assign count_new = record ? count_q + CntW'(1) : count_q;

  always_comb begin
    count_d = count_q;
    if (cmd_i.emit) begin
      count_d = item_last_q ? '0 : count_new;
    end
  end

  // Status towards the controller
  assign status_o.hit       = cmp_vld_q && (rdata_q == item_q);
  assign status_o.exhausted = (idx_q >= count_q);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit && record) begin
      mem_q[count_q[AddrW-1:0]] <= item_q;
    end
    if (rd_en) begin
      rdata_q <= mem_q[idx_q[AddrW-1:0]];
    end
  end

  // Item and decision registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      item_q      <= value_i;
      item_last_q <= last_i;
    end
    if (cmd_i.decide) begin
      keep_q <= cmd_i.keep;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
      count_q   <= '0;
    end else begin
      idx_q     <= idx_d;
      cmp_vld_q <= cmp_vld_d;
      count_q   <= count_d;
    end
  end

  // Output register: hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_value_q <= item_q;
      out_keep_q  <= keep_q;
      out_last_q  <= item_last_q;
      out_ovf_q   <= keep_q && !room;
      out_kept_q  <= sdr_pkg::KeptW'(count_new);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = out_value_q;
  assign keep_o       = out_keep_q;
  assign last_o       = out_last_q;
  assign overflow_o   = out_ovf_q;
  assign kept_count_o = out_kept_q;

`ifndef ASSERT_OFF
  // A result never overwrites one still waiting
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result loaded while output register busy");

  // The walk never passes the recorded entries
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= CntFull) && (!cmd_i.scan || (idx_q <= count_q)))
    else $error("scan pointer or count out of range");

  // The end of an array empties the table
  a_last_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && item_last_q) |=> (count_q == '0))
    else $error("table not cleared after last item");

  // Overflow only with a full table
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && keep_q && !item_last_q && !room) |=> (count_q == CntFull))
    else $error("overflow reported with room in the table");
`endif

endmodule

[rtl/stream_duplicate_remover.sv]
// A repeat ends the table walk at its match; a new value is compared with every
//   recorded value, at most TABLE_DEPTH. Output stalls delay the result.
// A new item is accepted only after the previous result is loaded into the output
//   register; the single table read port compares one recorded entry per cycle.
// Reset: asynchronous, active low; clears the count, the controller and the
//   output valid. Table contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// stream_duplicate_remover: keep first occurrences in each array
// Compares each item against the values recorded for the current array and
// marks it kept or dropped; the table empties after the item flagged last.
// ----------------------------------------------------------------------------
module stream_duplicate_remover #(
  parameter int unsigned TABLE_DEPTH = sdr_pkg::TableDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  logic        s_axis_tlast_i,   // last_of_array
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] value_out, [39:32] kept_count
  output logic [1:0]  m_axis_tuser_o,   // [0] keep, [1] overflow
  output logic        m_axis_tlast_o    // last_out
);

  sdr_pkg::cmd_t              cmd;
  sdr_pkg::status_t           status;
  logic [sdr_pkg::ValueW-1:0] value_out;
  logic [sdr_pkg::KeptW-1:0]  kept_count;
  logic                       keep;
  logic                       overflow;

  // Sequencer
  sdr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Table, comparator and output register
  sdr_dpath #(
    .TableDepth (TABLE_DEPTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .value_i      (s_axis_tdata_i),
    .last_i       (s_axis_tlast_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .value_o      (value_out),
    .keep_o       (keep),
    .last_o       (m_axis_tlast_o),
    .overflow_o   (overflow),
    .kept_count_o (kept_count)
  );

  // Pack the result item
  assign m_axis_tdata_o = {kept_count, value_out};
  assign m_axis_tuser_o = {overflow, keep};

endmodule
